### src/irpf_pkg.sv
// ----------------------------------------------------------------------------
// irpf_pkg
// Shared constants for the isolated range point filter: parameter defaults,
// register map and register reset values.
// ----------------------------------------------------------------------------
package irpf_pkg;

  localparam int DEF_MAX_BEAMS  = 4096;
  localparam int DEF_RANGE_BITS = 16;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_NEAR_LIMIT  = 3'd0,
    REG_ISO_THRESH  = 3'd1,
    REG_SKIP_START  = 3'd2,
    REG_SKIP_END    = 3'd3,
    REG_BEAMS       = 3'd4,
    REG_VALID_MIN   = 3'd5,
    REG_VALID_MAX   = 3'd6,
    REG_WARMUP      = 3'd7
  } reg_index_t;

  localparam logic [15:0] RST_NEAR_LIMIT = 16'd2000;
  localparam logic [15:0] RST_ISO_THRESH = 16'd50;
  localparam logic [11:0] RST_SKIP_START = 12'd2;
  localparam logic [11:0] RST_SKIP_END   = 12'd2;
  localparam logic [12:0] RST_BEAMS      = 13'd1024;
  localparam logic [15:0] RST_VALID_MIN  = 16'd0;
  localparam logic [15:0] RST_VALID_MAX  = 16'd65534;
  localparam logic [7:0]  RST_WARMUP     = 8'd1;

endpackage

### src/isolated_range_point_filter.sv
// ----------------------------------------------------------------------------
// isolated_range_point_filter
// Three-sample window over a beam stream; zeroes near, in-window beams that
// stand apart from both neighbors. Results queue in a four-word buffer.
// A beam's result is written to the buffer when the next beam is taken.
// Throughput: one beam per cycle while two or fewer words wait, set by the
// window compare; the buffer absorbs the second result of a scan's last beam.
// Reset: synchronous, active high; clears window, counters, buffer and
// restores register defaults.
// ----------------------------------------------------------------------------
module isolated_range_point_filter
  import irpf_pkg::*;
#(
  parameter int MAX_BEAMS  = DEF_MAX_BEAMS,
  parameter int RANGE_BITS = DEF_RANGE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  range_valid,
  output logic                  range_ready,
  input  logic [RANGE_BITS-1:0] range_mm,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [RANGE_BITS-1:0] out_range_mm,
  output logic                  removed,
  output logic                  end_of_scan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  localparam int PW    = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int NW    = (PW + 1 > 13) ? PW + 1 : 13;
  localparam int CW    = NW + 2;
  localparam int VW    = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int DEPTH = 4;
  localparam int QW    = $clog2(DEPTH);

  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic                  rm;
    logic                  eos;
  } result_t;

  logic [15:0] near_limit;
  logic [15:0] iso_thresh;
  logic [11:0] skip_start;
  logic [11:0] skip_end;
  logic [12:0] beams;
  logic [15:0] valid_min;
  logic [15:0] valid_max;
  logic [7:0]  warmup;

  logic [RANGE_BITS-1:0] older;
  logic [RANGE_BITS-1:0] held;
  logic [PW-1:0]         pos;
  logic [7:0]            scans;

  result_t       queue [DEPTH];
  logic [QW-1:0] wptr;
  logic [QW-1:0] rptr;
  logic [QW:0]   count;

  logic                  cfg_wr;
  reg_index_t            cfg_sel;
  logic [NW-1:0]         n_eff;
  logic                  is_last;
  logic                  has_prev;
  logic                  in_window;
  logic                  in_valid_range;
  logic [RANGE_BITS-1:0] diff_prev;
  logic [RANGE_BITS-1:0] diff_next;
  logic                  rm;
  result_t               res_prev;
  result_t               res_last;
  logic                  take;
  logic                  give;
  logic [1:0]            npush;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_index_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= RST_NEAR_LIMIT;
      iso_thresh <= RST_ISO_THRESH;
      skip_start <= RST_SKIP_START;
      skip_end   <= RST_SKIP_END;
      beams      <= RST_BEAMS;
      valid_min  <= RST_VALID_MIN;
      valid_max  <= RST_VALID_MAX;
      warmup     <= RST_WARMUP;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_NEAR_LIMIT: near_limit <= pwdata[15:0];
        REG_ISO_THRESH: iso_thresh <= pwdata[15:0];
        REG_SKIP_START: skip_start <= pwdata[11:0];
        REG_SKIP_END:   skip_end   <= pwdata[11:0];
        REG_BEAMS:      beams      <= pwdata[12:0];
        REG_VALID_MIN:  valid_min  <= pwdata[15:0];
        REG_VALID_MAX:  valid_max  <= pwdata[15:0];
        REG_WARMUP:     warmup     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_NEAR_LIMIT: prdata = DATA_BITS'(near_limit);
      REG_ISO_THRESH: prdata = DATA_BITS'(iso_thresh);
      REG_SKIP_START: prdata = DATA_BITS'(skip_start);
      REG_SKIP_END:   prdata = DATA_BITS'(skip_end);
      REG_BEAMS:      prdata = DATA_BITS'(beams);
      REG_VALID_MIN:  prdata = DATA_BITS'(valid_min);
      REG_VALID_MAX:  prdata = DATA_BITS'(valid_max);
      REG_WARMUP:     prdata = DATA_BITS'(warmup);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (NW'(beams) > NW'(MAX_BEAMS)) begin
      n_eff = NW'(MAX_BEAMS);
    end else if (beams == '0) begin
      n_eff = NW'(1);
    end else begin
      n_eff = NW'(beams);
    end
  end

  assign is_last   = (CW'(pos) + CW'(1)) >= CW'(n_eff);
  assign has_prev  = (pos != '0);
  assign in_window = (CW'(pos) >= CW'(skip_start) + CW'(3)) &&
                     (CW'(pos) + CW'(skip_end) + CW'(3) <= CW'(n_eff));
  assign in_valid_range = (VW'(held) >= VW'(valid_min)) && (VW'(held) <= VW'(valid_max));
  assign diff_prev = (held > older) ? held - older : older - held;
  assign diff_next = (held > range_mm) ? held - range_mm : range_mm - held;

  assign rm = (scans >= warmup) && in_window && in_valid_range &&
              (VW'(held) < VW'(near_limit)) &&
              (VW'(diff_prev) > VW'(iso_thresh)) &&
              (VW'(diff_next) > VW'(iso_thresh));

  assign res_prev = '{range: rm ? '0 : held, rm: rm, eos: 1'b0};
  assign res_last = '{range: range_mm, rm: 1'b0, eos: 1'b1};

  assign range_ready  = (count <= (QW+1)'(DEPTH - 2));
  assign take         = range_valid && range_ready;
  assign result_valid = (count != '0);
  assign give         = result_valid && result_ready;
  assign npush        = take ? (2'(has_prev) + 2'(is_last)) : 2'd0;

  assign out_range_mm = queue[rptr].range;
  assign removed      = queue[rptr].rm;
  assign end_of_scan  = queue[rptr].eos;

  always_ff @(posedge clk) begin
    if (take) begin
      queue[wptr] <= has_prev ? res_prev : res_last;
      if (has_prev && is_last) begin
        queue[wptr + QW'(1)] <= res_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QW'(npush);
      rptr  <= rptr + QW'(give);
      count <= count + (QW+1)'(npush) - (QW+1)'(give);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older <= '0;
      held  <= '0;
      pos   <= '0;
      scans <= '0;
    end else if (take) begin
      older <= held;
      held  <= range_mm;
      if (is_last) begin
        pos <= '0;
        if (scans != 8'hFF) begin
          scans <= scans + 8'd1;
        end
      end else begin
        pos <= pos + PW'(1);
      end
    end
  end

endmodule

### src/irpf_checker.sv
// ----------------------------------------------------------------------------
// irpf_checker
// Port-level checks for the isolated range point filter, bound to the top.
// ----------------------------------------------------------------------------
module irpf_checker
  import irpf_pkg::*;
#(
  parameter int RANGE_BITS = DEF_RANGE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  range_valid,
  input logic                  range_ready,
  input logic [RANGE_BITS-1:0] range_mm,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [RANGE_BITS-1:0] out_range_mm,
  input logic                  removed,
  input logic                  end_of_scan
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    range_valid && !range_ready |=> range_valid && $stable(range_mm))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_range_mm) && $stable(removed) && $stable(end_of_scan))
    else $error("result word dropped or changed while stalled");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && removed |-> out_range_mm == '0 && !end_of_scan)
    else $error("removed beam not zeroed or flagged as scan end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present after reset");

endmodule

bind isolated_range_point_filter irpf_checker #(.RANGE_BITS(RANGE_BITS)) u_irpf_checker (
  .clk          (clk),
  .rst          (rst),
  .range_valid  (range_valid),
  .range_ready  (range_ready),
  .range_mm     (range_mm),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_range_mm (out_range_mm),
  .removed      (removed),
  .end_of_scan  (end_of_scan)
);

### verif/irpf_checker.sv
// ----------------------------------------------------------------------------
// irpf_scoreboard
// Follows the register writes, the beam stream and the result stream of the
// isolated range point filter. Keeps its own window, scan position and scan
// count, works out the result words of each accepted beam and compares every
// returned word field by field with the oldest word still awaited.
// ----------------------------------------------------------------------------
module irpf_scoreboard
  import irpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 range_valid,
  input  logic                 range_ready,
  input  logic [15:0]          range_mm,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [15:0]          out_range_mm,
  input  logic                 removed,
  input  logic                 end_of_scan,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] beam_range;
    logic        zeroed;
    logic        scan_end;
  } beam_word_t;

  beam_word_t  awaited_words[$];

  logic [15:0] near_lim;
  logic [15:0] iso_thr;
  logic [11:0] skip_head;
  logic [11:0] skip_tail;
  logic [12:0] scan_len;
  logic [15:0] floor_mm;
  logic [15:0] ceil_mm;
  logic [7:0]  warmup;

  logic [15:0] prior2;
  logic [15:0] prior1;
  logic [11:0] pos;
  logic [7:0]  scans_done;

  function automatic logic [15:0] spread(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit isolated(input int idx, input int n, input logic [15:0] prv,
                                  input logic [15:0] cur, input logic [15:0] nxt);
    int lo;
    int hi;
    lo = int'(skip_head) + 2;
    hi = n - int'(skip_tail) - 4;
    if (scans_done < warmup) return 1'b0;
    if (idx < lo || idx > hi) return 1'b0;
    if (cur < floor_mm || cur > ceil_mm) return 1'b0;
    if (cur >= near_lim) return 1'b0;
    return spread(cur, prv) > iso_thr && spread(cur, nxt) > iso_thr;
  endfunction

  task automatic take_beam(input logic [15:0] cur);
    int n;
    bit is_tail;
    bit hit;
    n = int'(scan_len);
    if (n > DEF_MAX_BEAMS) n = DEF_MAX_BEAMS;
    if (n < 1) n = 1;
    is_tail = int'(pos) + 1 >= n;
    if (pos != '0) begin
      hit = isolated(int'(pos) - 1, n, prior2, prior1, cur);
      awaited_words.push_back('{hit ? 16'd0 : prior1, hit, 1'b0});
    end
    if (is_tail) begin
      awaited_words.push_back('{cur, 1'b0, 1'b1});
      pos = '0;
      if (scans_done != 8'd255) scans_done++;
    end else begin
      pos++;
    end
    prior2 = prior1;
    prior1 = cur;
  endtask

  always @(posedge clk) begin
    beam_word_t want;
    if (rst) begin
      near_lim   = RST_NEAR_LIMIT;
      iso_thr    = RST_ISO_THRESH;
      skip_head  = RST_SKIP_START;
      skip_tail  = RST_SKIP_END;
      scan_len   = RST_BEAMS;
      floor_mm   = RST_VALID_MIN;
      ceil_mm    = RST_VALID_MAX;
      warmup     = RST_WARMUP;
      prior2     = '0;
      prior1     = '0;
      pos        = '0;
      scans_done = '0;
      awaited_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_NEAR_LIMIT: near_lim  = pwdata[15:0];
          REG_ISO_THRESH: iso_thr   = pwdata[15:0];
          REG_SKIP_START: skip_head = pwdata[11:0];
          REG_SKIP_END:   skip_tail = pwdata[11:0];
          REG_BEAMS:      scan_len  = pwdata[12:0];
          REG_VALID_MIN:  floor_mm  = pwdata[15:0];
          REG_VALID_MAX:  ceil_mm   = pwdata[15:0];
          REG_WARMUP:     warmup    = pwdata[7:0];
          default: ;
        endcase
      end
      if (range_valid && range_ready) take_beam(range_mm);
      if (result_valid && result_ready) begin
        if (awaited_words.size() == 0) begin
          errors++;
          $error("result word with nothing awaited: out_range_mm %0d", out_range_mm);
        end else begin
          want = awaited_words.pop_front();
          if (out_range_mm !== want.beam_range) begin
            errors++;
            $error("out_range_mm: expected %0d, actual %0d", want.beam_range, out_range_mm);
          end
          if (removed !== want.zeroed) begin
            errors++;
            $error("removed: expected %0d, actual %0d", want.zeroed, removed);
          end
          if (end_of_scan !== want.scan_end) begin
            errors++;
            $error("end_of_scan: expected %0d, actual %0d", want.scan_end, end_of_scan);
          end
        end
      end
    end
    pending <= awaited_words.size();
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the isolated range point filter: a short directed set of scans
// (isolated spike, equal-threshold neighbor, valid window edges, one-beam
// scans, oversize count cut short mid-scan), then random scans over random
// register settings with random gaps on both streams. The checker compares
// every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irpf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TOTAL_BEAMS = 1800;

  localparam logic [15:0] SPIKE_SCAN [8] = '{16'd65535, 16'd3000, 16'd120, 16'd3000,
                                              16'd1500, 16'd1550, 16'd0, 16'd65535};
  localparam logic [15:0] WINDOW_SCAN [8] = '{16'd0, 16'd0, 16'd150, 16'd900,
                                               16'd1001, 16'd0, 16'd0, 16'd0};

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 range_valid  = 1'b0;
  logic                 range_ready;
  logic [15:0]          range_mm     = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [15:0]          out_range_mm;
  logic                 removed;
  logic                 end_of_scan;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [ADDR_BITS-1:0] paddr        = '0;
  logic [DATA_BITS-1:0] pwdata       = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 steady       = 1'b0;
  int                   errors;
  int                   pending;
  int                   quiet_cycles = 0;

  isolated_range_point_filter i_dut (.*);

  irpf_scoreboard i_check (.*);

  always #5 clk = ~clk;

  always @(posedge clk) result_ready <= steady || ($urandom_range(99) >= 28);

  always @(posedge clk) begin
    if (rst || (range_valid && range_ready) || (result_valid && result_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("isolated_range_point_filter: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int edge_or(input int lo, input int hi, input int typ_lo,
                                 input int typ_hi);
    int draw;
    draw = $urandom_range(99);
    if (draw < 8) return lo;
    if (draw < 15) return hi;
    return $urandom_range(typ_hi, typ_lo);
  endfunction

  task automatic send_beam(input logic [15:0] value);
    if (!steady && $urandom_range(99) < 28) begin
      range_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    range_valid <= 1'b1;
    range_mm    <= value;
    do @(posedge clk); while (!range_ready);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int near_v, input int thr, input int skip_s,
                           input int skip_e, input int beams, input int vmin,
                           input int vmax, input int warm);
    range_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_NEAR_LIMIT, near_v);
    write_reg(REG_ISO_THRESH, thr);
    write_reg(REG_SKIP_START, skip_s);
    write_reg(REG_SKIP_END, skip_e);
    write_reg(REG_BEAMS, beams);
    write_reg(REG_VALID_MIN, vmin);
    write_reg(REG_VALID_MAX, vmax);
    write_reg(REG_WARMUP, warm);
  endtask

  initial begin
    int sent;
    int phase;
    int span;
    int bg;
    int jit;
    int near_v;
    int thr;
    int vmin;
    int vmax;
    int beams;
    int draw;
    int value;
    int hi;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    configure(2000, 50, 0, 0, 8, 0, 65534, 0);
    foreach (SPIKE_SCAN[i]) send_beam(SPIKE_SCAN[i]);
    configure(65535, 0, 0, 0, 8, 200, 1000, 0);
    foreach (WINDOW_SCAN[i]) send_beam(WINDOW_SCAN[i]);
    configure(0, 65535, 0, 0, 0, 0, 65535, 0);
    send_beam(16'd0);
    send_beam(16'd65535);
    send_beam(16'h5a5a);
    configure(65535, 0, 4095, 4095, 8191, 0, 65535, 255);
    repeat (5) send_beam(16'($urandom));
    configure(65535, 0, 4095, 4095, 2, 0, 65535, 255);
    send_beam(16'd777);

    sent  = 0;
    phase = 0;
    while (sent < TOTAL_BEAMS) begin
      steady <= (sent >= 700 && sent < 1000);
      near_v = edge_or(0, 65535, 500, 65535);
      thr    = edge_or(0, 65535, 0, 600);
      vmin   = edge_or(0, 65535, 0, 300);
      vmax   = edge_or(0, 65535, 30000, 65535);
      draw   = $urandom_range(99);
      if (phase == 3) begin
        beams = 1;
        span  = 270;
      end else if (draw < 4) begin
        beams = $urandom_range(8191, 4096);
        span  = $urandom_range(40, 20);
      end else if (draw < 12) begin
        beams = $urandom_range(3, 0);
        span  = $urandom_range(140, 40);
      end else if (draw < 20) begin
        beams = $urandom_range(300, 41);
        span  = $urandom_range(140, 40);
      end else begin
        beams = $urandom_range(40, 8);
        span  = $urandom_range(140, 40);
      end
      configure(near_v, thr, edge_or(0, 4095, 0, 4), edge_or(0, 4095, 0, 4), beams,
                vmin, vmax, edge_or(0, 255, 0, 2));
      bg  = $urandom_range(65535, 0);
      jit = (thr > 1000) ? 1000 : thr;
      hi  = (vmax < near_v - 1) ? vmax : near_v - 1;
      repeat (span) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: value = bg + int'($urandom_range(2 * jit, 0)) - jit;
          5, 6: begin
            if (vmin <= hi) value = $urandom_range(hi, vmin);
            else value = $urandom_range(65535, 0);
          end
          7: begin
            case ($urandom_range(5))
              0: value = 0;
              1: value = 65535;
              2: value = vmin;
              3: value = vmax;
              4: value = bg + thr;
              default: value = bg - thr;
            endcase
          end
          default: value = $urandom_range(65535, 0);
        endcase
        if (value < 0) value = 0;
        if (value > 65535) value = 65535;
        send_beam(16'(value));
        sent++;
      end
      phase++;
    end
    range_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("isolated_range_point_filter: match");
    end else begin
      $display("isolated_range_point_filter: mismatch");
    end
    $finish;
  end

endmodule
